>>> rtl/core/lmfs_pkg.sv
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared constants, codes and types of the LED matrix frame streamer.
// ----------------------------------------------------------------------------
package lmfs_pkg;

	localparam int MAX_DEVICES  = 4;
	localparam int ROWS         = 8;
	localparam int STORE_DEPTH  = ROWS * MAX_DEVICES;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W        = $clog2(MAX_DEVICES + 1);
	localparam int DEV_W        = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

	localparam logic [7:0] ROW_ADDR_BASE = 8'h01;

	// Item kinds.
	localparam logic [1:0] KIND_SET   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_ROW   = 2'd2;
	localparam logic [1:0] KIND_CMD   = 2'd3;

	// Register selects (word address bit).
	localparam logic REG_NUM_DEVICES = 1'b0;
	localparam logic REG_ROTATED     = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_STR_ADDR,
		ST_STR_DATA
	} seq_state_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
	} store_ctrl_t;

	function automatic logic [ADDR_W-1:0] store_addr(logic [2:0] srow,
	                                                 logic [DEV_W-1:0] dev);
		return ADDR_W'(int'(srow) * MAX_DEVICES + int'(dev));
	endfunction

endpackage

>>> rtl/core/lmfs_store.sv
// ----------------------------------------------------------------------------
// lmfs_store
// Frame store: one byte per row per device, registered read, per-entry
// valid bits so that every entry reads as zero after reset.
// ----------------------------------------------------------------------------
module lmfs_store
	import lmfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  store_ctrl_t ctrl,
	output logic [7:0]  rd_data
);

	logic [7:0]             mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;
	logic [7:0]             rd_data_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[ctrl.wr_addr] <= ctrl.wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= valid_q[ctrl.rd_addr] ? mem_q[ctrl.rd_addr] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.wr_en) begin
			valid_q[ctrl.wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/lmfs_seq.sv
// ----------------------------------------------------------------------------
// lmfs_seq
// Item sequencer: takes one item, drives the frame store through a
// read-modify-write or a per-device byte loop, and holds the output register.
// ----------------------------------------------------------------------------
module lmfs_seq
	import lmfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  num_devices,
	input  logic        rotated,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [2:0]  row,
	input  logic [4:0]  col,
	input  logic [7:0]  command_byte,
	input  logic [7:0]  value_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  spi_byte,
	output logic        has_byte,
	output logic        last,
	output logic        accepted,
	output store_ctrl_t ctrl,
	input  logic [7:0]  rd_data
);

	seq_state_t       state_q, state_d;
	logic [1:0]       kind_q;
	logic [2:0]       row_q;
	logic [4:0]       col_q;
	logic [7:0]       cmd_q;
	logic [7:0]       val_q;
	logic [CNT_W-1:0] n_q;
	logic [DEV_W-1:0] dev_q;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_has_q;
	logic             out_last_q;
	logic             out_acc_q;

	logic             in_take;
	logic             out_free;
	logic [CNT_W-1:0] live_n;
	logic             pix_ok;
	logic [2:0]       pix_srow;
	logic [2:0]       pix_bit;
	logic [7:0]       pix_mask;
	logic [7:0]       pix_byte;
	logic [DEV_W-1:0] pix_dev;
	logic             dev_fin;

	logic             out_load;
	logic [7:0]       load_byte;
	logic             load_has;
	logic             load_last;
	logic             load_acc;
	logic             dev_inc;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// A device count of zero behaves as one; anything above the maximum is clamped.
	always_comb begin
		if (num_devices == 3'd0) begin
			live_n = CNT_W'(1);
		end else if (int'(num_devices) > MAX_DEVICES) begin
			live_n = CNT_W'(MAX_DEVICES);
		end else begin
			live_n = CNT_W'(num_devices);
		end
	end

	assign pix_ok   = int'(col_q[4:3]) < int'(n_q);
	assign pix_dev  = DEV_W'(col_q[4:3]);
	assign pix_srow = rotated ? col_q[2:0] : (3'd7 - row_q);
	assign pix_bit  = rotated ? row_q : col_q[2:0];
	assign pix_mask = 8'h01 << pix_bit;
	assign pix_byte = (kind_q == KIND_SET) ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
	assign dev_fin  = (CNT_W'(dev_q) + CNT_W'(1)) == n_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = (kind == KIND_SET || kind == KIND_CLEAR) ? ST_PIX_RD : ST_STR_ADDR;
				end
			end
			ST_PIX_RD: begin
				state_d = ST_PIX_WR;
			end
			ST_PIX_WR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_STR_ADDR: begin
				if (out_free) begin
					state_d = ST_STR_DATA;
				end
			end
			ST_STR_DATA: begin
				if (out_free) begin
					state_d = dev_fin ? ST_IDLE : ST_STR_ADDR;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl      = '0;
		out_load  = 1'b0;
		load_byte = 8'h00;
		load_has  = 1'b0;
		load_last = 1'b0;
		load_acc  = 1'b1;
		dev_inc   = 1'b0;
		case (state_q)
			ST_PIX_RD: begin
				ctrl.rd_en   = 1'b1;
				ctrl.rd_addr = store_addr(pix_srow, pix_dev);
			end
			ST_PIX_WR: begin
				if (out_free) begin
					ctrl.wr_en   = pix_ok;
					ctrl.wr_addr = store_addr(pix_srow, pix_dev);
					ctrl.wr_data = pix_byte;
					out_load     = 1'b1;
					load_last    = 1'b1;
					load_acc     = pix_ok;
				end
			end
			ST_STR_ADDR: begin
				if (out_free) begin
					ctrl.rd_en   = (kind_q == KIND_ROW);
					ctrl.rd_addr = store_addr(row_q, dev_q);
					out_load     = 1'b1;
					load_has     = 1'b1;
					load_byte    = (kind_q == KIND_ROW) ? (8'(row_q) + ROW_ADDR_BASE) : cmd_q;
				end
			end
			ST_STR_DATA: begin
				if (out_free) begin
					out_load  = 1'b1;
					load_has  = 1'b1;
					load_last = dev_fin;
					load_byte = (kind_q == KIND_ROW) ? rd_data : val_q;
					dev_inc   = !dev_fin;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			dev_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_take) begin
				dev_q <= '0;
			end else if (dev_inc) begin
				dev_q <= dev_q + DEV_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_q <= kind;
			row_q  <= row;
			col_q  <= col;
			cmd_q  <= command_byte;
			val_q  <= value_byte;
			n_q    <= live_n;
		end
		if (out_load) begin
			out_byte_q <= load_byte;
			out_has_q  <= load_has;
			out_last_q <= load_last;
			out_acc_q  <= load_acc;
		end
	end

	assign out_valid = out_valid_q;
	assign spi_byte  = out_byte_q;
	assign has_byte  = out_has_q;
	assign last      = out_last_q;
	assign accepted  = out_acc_q;

endmodule

>>> rtl/core/led_matrix_frame_streamer_top.sv
// ----------------------------------------------------------------------------
// led_matrix_frame_streamer_top
// Frame store and byte streamer for a chain of 8x8 LED matrix driver devices.
// ----------------------------------------------------------------------------
// The block holds eight rows of one byte per device, all zero after reset.
// A set or clear item changes one pixel with a read-modify-write of one store
// byte and returns a single item with has_byte low, last high and accepted
// telling whether the column fell inside the configured chain. A row item
// returns an address byte (row plus one) and a data byte for every device,
// device 0 first; a command item returns the same command and value pair for
// every device. last marks the final item, after which chip select may be
// released. Only one input item is worked on at a time: a pixel item passes
// a store read state and a write state, and a row or command item passes an
// address state and a data state for each device in use, with the sequencer
// stepping the single store read port and the output register and holding
// while the output is stalled. Configuration sits on an APB-style port:
// num_devices at byte address 0 and rotated at byte address 4; it must
// only be written while the block is idle.
// ----------------------------------------------------------------------------
module led_matrix_frame_streamer_top
	import lmfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input items.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [2:0]  row,
	input  logic [4:0]  col,
	input  logic [7:0]  command_byte,
	input  logic [7:0]  value_byte,
	// Result items.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  spi_byte,
	output logic        has_byte,
	output logic        last,
	output logic        accepted
);

	logic [2:0]  num_devices_q;
	logic        rotated_q;
	logic        cfg_write;
	store_ctrl_t store_ctrl;
	logic [7:0]  store_rd_data;

	// The register interface never inserts wait states.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Word select is taken from address bit 2; the byte offset bits are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_devices_q <= 3'd1;
			rotated_q     <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_NUM_DEVICES: num_devices_q <= pwdata[2:0];
				REG_ROTATED:     rotated_q     <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_NUM_DEVICES: prdata = {29'd0, num_devices_q};
			REG_ROTATED:     prdata = {31'd0, rotated_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Sequencer with the output register; it drives the store's read and write ports.
	lmfs_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.num_devices  (num_devices_q),
		.rotated      (rotated_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.row          (row),
		.col          (col),
		.command_byte (command_byte),
		.value_byte   (value_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.spi_byte     (spi_byte),
		.has_byte     (has_byte),
		.last         (last),
		.accepted     (accepted),
		.ctrl         (store_ctrl),
		.rd_data      (store_rd_data)
	);

	// Frame store, indexed by store row times the largest chain length plus
	// device.
	lmfs_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (store_ctrl),
		.rd_data (store_rd_data)
	);

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED matrix frame streamer. A driver offers pixel,
// row and command items from a queue and a monitor checks every serial byte
// against a frame store mirror kept inside the bench, over several chain
// configurations, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import lmfs_pkg::*;

	// The watchdog limit covers the long receiver hold with plenty of margin.
	localparam int IDLE_LIMIT      = 2000;
	localparam int SETTLE_CYCLES   = 12;
	localparam int LONG_HOLD       = 200;
	localparam int ITEMS_PER_PHASE = 17;
	localparam int PHASES          = 8;

	// Byte addresses of the two registers; the word bit comes from the package.
	localparam logic [2:0] ADDR_NUM_DEVICES = {REG_NUM_DEVICES, 2'b00};
	localparam logic [2:0] ADDR_ROTATED     = {REG_ROTATED, 2'b00};

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] row;
		logic [4:0] col;
		logic [7:0] command_byte;
		logic [7:0] value_byte;
	} pixel_cmd_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       has_byte;
		logic       last;
		logic       accepted;
	} serial_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [2:0]  row = '0;
	logic [4:0]  col = '0;
	logic [7:0]  command_byte = '0;
	logic [7:0]  value_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  spi_byte;
	logic        has_byte;
	logic        last;
	logic        accepted;

	// Items waiting to be offered, and the serial bytes still owed by the block.
	pixel_cmd_t   pending_items [$];
	serial_word_t serial_due [$];

	// Bench copy of the frame store and of the two registers.
	logic [7:0] frame_copy [ROWS][MAX_DEVICES];
	logic [2:0] chain_cfg = 3'd1;
	logic       turn_cfg = 1'b0;

	// Pacing controls, set by the sequence and read by the driver and monitor.
	logic calm = 1'b0;
	logic hold_receiver = 1'b0;
	int   send_gap = 0;
	int   recv_wait = 0;
	int   quiet_cycles = 0;
	int   errors = 0;

	led_matrix_frame_streamer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.row          (row),
		.col          (col),
		.command_byte (command_byte),
		.value_byte   (value_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.spi_byte     (spi_byte),
		.has_byte     (has_byte),
		.last         (last),
		.accepted     (accepted)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A device count of zero behaves as one, and anything above the chain
	// length the block was built for behaves as the full chain.
	function automatic int devices_in_use();
		if (chain_cfg == 3'd0)
			return 1;
		if (int'(chain_cfg) > MAX_DEVICES)
			return MAX_DEVICES;
		return int'(chain_cfg);
	endfunction

	// Works out the serial bytes that one accepted item produces and keeps the
	// frame store copy in step with pixel changes.
	task automatic stream_bytes(input pixel_cmd_t it);
		int n;
		int dev;
		int d;
		logic [2:0] srow;
		logic [2:0] bitpos;
		logic ok;
		logic [7:0] addr_byte;
		logic [7:0] data_byte;
		n = devices_in_use();
		if (it.kind == KIND_SET || it.kind == KIND_CLEAR) begin
			dev = int'(it.col[4:3]);
			ok = (dev < n);
			if (ok) begin
				// Rotated orientation swaps row and bit; normal orientation
				// mirrors the row instead.
				if (turn_cfg) begin
					srow = it.col[2:0];
					bitpos = it.row;
				end else begin
					srow = 3'd7 - it.row;
					bitpos = it.col[2:0];
				end
				frame_copy[srow][dev][bitpos] = (it.kind == KIND_SET);
			end
			serial_due.push_back({8'h00, 1'b0, 1'b1, ok});
		end else begin
			for (d = 0; d < n; d++) begin
				if (it.kind == KIND_ROW) begin
					addr_byte = {5'd0, it.row} + ROW_ADDR_BASE;
					data_byte = frame_copy[it.row][d];
				end else begin
					addr_byte = it.command_byte;
					data_byte = it.value_byte;
				end
				serial_due.push_back({addr_byte, 1'b1, 1'b0, 1'b1});
				serial_due.push_back({data_byte, 1'b1, (d + 1 == n), 1'b1});
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("tb: mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
	endtask

	// Driver: offers the next pending item once the drawn gap has run out. The
	// valid line is worked out in a variable first so that it only ever gets
	// one assignment per edge.
	always @(posedge clk or negedge arst_n) begin : feed
		logic offering;
		pixel_cmd_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			offering = in_valid;
			if (in_valid && !in_stall) begin
				stream_bytes({kind, row, col, command_byte, value_byte});
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (pending_items.size() > 0) begin
					nxt = pending_items.pop_front();
					kind <= nxt.kind;
					row <= nxt.row;
					col <= nxt.col;
					command_byte <= nxt.command_byte;
					value_byte <= nxt.value_byte;
					offering = 1'b1;
					send_gap <= calm ? 0 : $urandom_range(0, 17);
				end
			end
			in_valid <= offering;
		end
	end

	// Monitor: takes each result item, compares it with the oldest expected
	// byte and then draws how long to stall before taking the next one.
	always @(posedge clk or negedge arst_n) begin : sink
		int w;
		serial_word_t got;
		serial_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
		end else begin
			w = recv_wait;
			if (out_valid && !out_stall) begin
				got = {spi_byte, has_byte, last, accepted};
				if (serial_due.size() == 0) begin
					report_mismatch("unexpected result", int'(got), 0);
				end else begin
					want = serial_due.pop_front();
					if (got.spi_byte !== want.spi_byte)
						report_mismatch("spi_byte", got.spi_byte, want.spi_byte);
					if (got.has_byte !== want.has_byte)
						report_mismatch("has_byte", got.has_byte, want.has_byte);
					if (got.last !== want.last)
						report_mismatch("last", got.last, want.last);
					if (got.accepted !== want.accepted)
						report_mismatch("accepted", got.accepted, want.accepted);
				end
				w = calm ? 0 : $urandom_range(0, 17);
			end else if (w > 0) begin
				w = w - 1;
			end
			recv_wait <= w;
			out_stall <= (w != 0) || hold_receiver;
		end
	end

	// Watchdog: any handshake or register access counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// A register write: setup cycle, then access cycle until pready is seen.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_NUM_DEVICES)
			chain_cfg = data[2:0];
		else if (addr == ADDR_ROTATED)
			turn_cfg = data[0];
	endtask

	// Writes both registers with random junk in the unused upper bits.
	task automatic set_chain(input logic [2:0] devices, input logic orient);
		logic [31:0] data;
		data = $urandom();
		data[2:0] = devices;
		apb_write(ADDR_NUM_DEVICES, data);
		data = $urandom();
		data[0] = orient;
		apb_write(ADDR_ROTATED, data);
	endtask

	task automatic queue_item(input logic [1:0] k, input logic [2:0] r, input logic [4:0] c,
	                          input logic [7:0] cmd, input logic [7:0] val);
		pending_items.push_back({k, r, c, cmd, val});
	endtask

	// Waits at falling edges, where everything has settled, until no item is
	// left to offer or in flight, then gives the block time to go idle.
	task automatic wait_until_settled();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || serial_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : run
		logic [2:0] chain_plan [PHASES];
		logic       turn_plan [PHASES];
		int p;
		int i;
		int pick;
		int reach;
		pixel_cmd_t it;
		chain_plan = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd3, 3'd1, 3'd5, 3'd4};
		turn_plan = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
		foreach (frame_copy[r, d])
			frame_copy[r][d] = 8'h00;

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items with the reset configuration: one device, normal
		// orientation. Corner pixels, a row that maps back to each of them,
		// columns beyond the single device, and extreme command bytes.
		@(negedge clk);
		queue_item(KIND_SET, 3'd0, 5'd0, 8'h00, 8'h00);
		queue_item(KIND_SET, 3'd7, 5'd7, 8'h00, 8'h00);
		queue_item(KIND_SET, 3'd3, 5'd5, 8'h00, 8'h00);
		queue_item(KIND_ROW, 3'd7, 5'd0, 8'h00, 8'h00);
		queue_item(KIND_ROW, 3'd0, 5'd0, 8'h00, 8'h00);
		queue_item(KIND_ROW, 3'd4, 5'd0, 8'h00, 8'h00);
		queue_item(KIND_SET, 3'd2, 5'd8, 8'h00, 8'h00);
		queue_item(KIND_CLEAR, 3'd7, 5'd31, 8'h00, 8'h00);
		queue_item(KIND_CLEAR, 3'd0, 5'd0, 8'h00, 8'h00);
		queue_item(KIND_ROW, 3'd7, 5'd31, 8'hFF, 8'hFF);
		queue_item(KIND_CMD, 3'd0, 5'd0, 8'h00, 8'hFF);
		queue_item(KIND_CMD, 3'd7, 5'd31, 8'hFF, 8'h00);
		wait_until_settled();

		// Full chain, rotated: the far device and the swapped mapping.
		set_chain(3'd4, 1'b1);
		@(negedge clk);
		queue_item(KIND_SET, 3'd7, 5'd31, 8'h00, 8'h00);
		queue_item(KIND_SET, 3'd0, 5'd24, 8'h00, 8'h00);
		queue_item(KIND_SET, 3'd5, 5'd16, 8'h00, 8'h00);
		queue_item(KIND_ROW, 3'd7, 5'd0, 8'h00, 8'h00);
		queue_item(KIND_CLEAR, 3'd7, 5'd31, 8'h00, 8'h00);
		queue_item(KIND_ROW, 3'd7, 5'd0, 8'h00, 8'h00);
		queue_item(KIND_ROW, 3'd0, 5'd0, 8'h00, 8'h00);
		queue_item(KIND_CMD, 3'd1, 5'd1, 8'h0C, 8'h01);
		queue_item(KIND_CMD, 3'd2, 5'd2, 8'h55, 8'hAA);
		wait_until_settled();

		// Random phases. Each one sets the chain, then offers mostly pixels
		// inside the configured devices mixed with rows that read them back,
		// plus some stray columns and broadcast commands.
		for (p = 0; p < PHASES; p++) begin
			set_chain(chain_plan[p], turn_plan[p]);
			@(negedge clk);
			calm <= (p == 1 || p == 5);
			reach = devices_in_use() * 8 - 1;
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				it = 26'($urandom());
				pick = $urandom_range(0, 99);
				if (pick < 35)
					it.kind = KIND_SET;
				else if (pick < 50)
					it.kind = KIND_CLEAR;
				else if (pick < 85)
					it.kind = KIND_ROW;
				else
					it.kind = KIND_CMD;
				if ($urandom_range(0, 4) != 0)
					it.col = 5'($urandom_range(0, reach));
				pending_items.push_back(it);
			end
			// In the second phase the receiver holds off for a long stretch
			// while the driver keeps offering, so the block has to back up.
			if (p == 1) begin
				hold_receiver <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_receiver <= 1'b0;
			end
			wait_until_settled();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/lmfs_pkg.sv
rtl/core/lmfs_store.sv
rtl/core/lmfs_seq.sv
rtl/core/led_matrix_frame_streamer_top.sv
bench/testbench.sv
